FILE: rtl/core/yfr_pkg.sv
package yfr_pkg;

    localparam int PIX_W   = 8;
    localparam int DELTA_W = 10;
    localparam int CHROMA_OFFSET = 128;
    localparam int PIX_MAX = 255;

    // Color matrix coefficients in thousandths
    localparam longint M_V_R = 1140;
    localparam longint M_U_G = 394;
    localparam longint M_V_G = 581;
    localparam longint M_U_B = 2032;
    localparam longint M_R_Y = 299;
    localparam longint M_G_Y = 587;
    localparam longint M_B_Y = 114;
    localparam longint M_R_U = 147;
    localparam longint M_G_U = 289;
    localparam longint M_B_U = 436;
    localparam longint M_R_V = 615;
    localparam longint M_G_V = 515;
    localparam longint M_B_V = 100;

    // Per-channel chroma contribution, shared by all four pixels of a block
    typedef struct packed {
        logic signed [DELTA_W-1:0] r;
        logic signed [DELTA_W-1:0] g;
        logic signed [DELTA_W-1:0] b;
    } yfr_delta_t;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } yfr_rgb_t;

endpackage

FILE: rtl/core/yfr_in_if.sv
interface yfr_in_if import yfr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma_0;
    logic [PIX_W-1:0] luma_1;
    logic [PIX_W-1:0] luma_2;
    logic [PIX_W-1:0] luma_3;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;

    modport source (
        output valid, luma_0, luma_1, luma_2, luma_3, chroma_u, chroma_v,
        input  ready
    );

    modport sink (
        input  valid, luma_0, luma_1, luma_2, luma_3, chroma_u, chroma_v,
        output ready
    );
endinterface

FILE: rtl/core/yfr_out_if.sv
interface yfr_out_if import yfr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_luma_0;
    logic [PIX_W-1:0] out_luma_1;
    logic [PIX_W-1:0] out_luma_2;
    logic [PIX_W-1:0] out_luma_3;
    logic [PIX_W-1:0] out_chroma_u;
    logic [PIX_W-1:0] out_chroma_v;

    modport source (
        output valid, out_luma_0, out_luma_1, out_luma_2, out_luma_3,
               out_chroma_u, out_chroma_v,
        input  ready
    );

    modport sink (
        input  valid, out_luma_0, out_luma_1, out_luma_2, out_luma_3,
               out_chroma_u, out_chroma_v,
        output ready
    );
endinterface

FILE: rtl/core/yfr_pixel.sv
module yfr_pixel import yfr_pkg::*; #(
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic             clk,
    input  logic             en,
    input  logic [PIX_W-1:0] alpha,
    input  logic [PIX_W-1:0] luma,
    input  yfr_delta_t       delta,
    output yfr_rgb_t         fade,
    output logic [PIX_W-1:0] luma_out
);

    localparam int CU = COEF_FRAC_BITS + 3;
    localparam int LW = COEF_FRAC_BITS + 11;
    localparam int SW = COEF_FRAC_BITS + 13;
    localparam int YW = SW - COEF_FRAC_BITS;
    localparam int CLW = PIX_W + 3;

    localparam longint Q_R_Y = (M_R_Y * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000;
    localparam longint Q_G_Y = (M_G_Y * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000;
    localparam longint Q_B_Y = (M_B_Y * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000;
    localparam logic [CU-1:0] C_R_Y = CU'(Q_R_Y);
    localparam logic [CU-1:0] C_G_Y = CU'(Q_G_Y);
    localparam logic [CU-1:0] C_B_Y = CU'(Q_B_Y);

    yfr_rgb_t                clip_reg, clip_next;
    yfr_rgb_t                fade_reg, fade_next;
    logic [LW-1:0]           pr_reg, pg_reg, pb_reg;
    logic [LW-1:0]           pr_next, pg_next, pb_next;
    logic [PIX_W-1:0]        luma_reg, luma_next;

    logic signed [CLW-1:0]   sum_r, sum_g, sum_b;
    logic [2*PIX_W-1:0]      fr, fg, fb;
    logic [SW-1:0]           ysum;
    logic [YW-1:0]           yint;

    function automatic logic [PIX_W-1:0] clip8(input logic signed [CLW-1:0] s);
        logic [PIX_W-1:0] res;
        if (s[CLW-1])
            res = '0;
        else if (s > CLW'(PIX_MAX))
            res = PIX_W'(PIX_MAX);
        else
            res = s[PIX_W-1:0];
        return res;
    endfunction

    // Add chroma terms and clip to pixel range
    always_comb
    begin
        sum_r = $signed({3'b000, luma}) + CLW'(delta.r);
        sum_g = $signed({3'b000, luma}) + CLW'(delta.g);
        sum_b = $signed({3'b000, luma}) + CLW'(delta.b);
        clip_next.r = clip8(sum_r);
        clip_next.g = clip8(sum_g);
        clip_next.b = clip8(sum_b);
    end

    // Fade: channel * alpha / 256, truncated
    always_comb
    begin
        fr = clip_reg.r * alpha;
        fg = clip_reg.g * alpha;
        fb = clip_reg.b * alpha;
        fade_next.r = fr[2*PIX_W-1:PIX_W];
        fade_next.g = fg[2*PIX_W-1:PIX_W];
        fade_next.b = fb[2*PIX_W-1:PIX_W];
    end

    always_comb
    begin
        pr_next = LW'(C_R_Y) * LW'(fade_reg.r);
        pg_next = LW'(C_G_Y) * LW'(fade_reg.g);
        pb_next = LW'(C_B_Y) * LW'(fade_reg.b);
    end

    // All terms are non-negative, so truncation is a plain shift
    always_comb
    begin
        ysum = SW'(pr_reg) + SW'(pg_reg) + SW'(pb_reg);
        yint = ysum[SW-1:COEF_FRAC_BITS];
        if (yint > YW'(PIX_MAX))
            luma_next = PIX_W'(PIX_MAX);
        else
            luma_next = yint[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clip_reg <= clip_next;
            fade_reg <= fade_next;
            pr_reg   <= pr_next;
            pg_reg   <= pg_next;
            pb_reg   <= pb_next;
            luma_reg <= luma_next;
        end
    end

    assign fade     = fade_reg;
    assign luma_out = luma_reg;

endmodule

FILE: rtl/core/yuv_fade_recode_2x2_core.sv
// Fades one 2x2 YUV block (four luma samples, one shared U/V pair) through
// RGB by alpha/256 and re-encodes it: new luma for every pixel, new U and V
// from the top-left pixel with the 128 offset restored and clipped to 0..255.
// One block is accepted per clock while the pipeline advances; the five-stage
// multiply/add pipeline halts as a whole while the output request is held.
// Write alpha (reset 255) only while the pipeline is empty.
module yuv_fade_recode_2x2_core import yfr_pkg::*; #(
    parameter int COEF_FRAC_BITS = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [PIX_W-1:0] cfg_wdata,
    yfr_in_if.sink           pix_in,
    yfr_out_if.source        pix_out
);

    localparam int NPIX = 4;
    localparam int NSTG = 5;
    localparam int CW = COEF_FRAC_BITS + 4;
    localparam int CU = COEF_FRAC_BITS + 3;
    localparam int PW = COEF_FRAC_BITS + 13;
    localparam int TW = PW - COEF_FRAC_BITS;
    localparam int LW = COEF_FRAC_BITS + 11;
    localparam int SW = COEF_FRAC_BITS + 13;
    localparam int NW = SW - COEF_FRAC_BITS + 1;

    localparam longint SCL = longint'(1) << COEF_FRAC_BITS;
    localparam longint Q_V_R = (M_V_R * SCL + 500) / 1000;
    localparam longint Q_U_G = (M_U_G * SCL + 500) / 1000;
    localparam longint Q_V_G = (M_V_G * SCL + 500) / 1000;
    localparam longint Q_U_B = (M_U_B * SCL + 500) / 1000;
    localparam longint Q_R_U = (M_R_U * SCL + 500) / 1000;
    localparam longint Q_G_U = (M_G_U * SCL + 500) / 1000;
    localparam longint Q_B_U = (M_B_U * SCL + 500) / 1000;
    localparam longint Q_R_V = (M_R_V * SCL + 500) / 1000;
    localparam longint Q_G_V = (M_G_V * SCL + 500) / 1000;
    localparam longint Q_B_V = (M_B_V * SCL + 500) / 1000;

    localparam logic signed [CW-1:0] C_V_R = CW'(Q_V_R);
    localparam logic signed [CW-1:0] C_U_G = CW'(Q_U_G);
    localparam logic signed [CW-1:0] C_V_G = CW'(Q_V_G);
    localparam logic signed [CW-1:0] C_U_B = CW'(Q_U_B);
    localparam logic [CU-1:0] C_R_U = CU'(Q_R_U);
    localparam logic [CU-1:0] C_G_U = CU'(Q_G_U);
    localparam logic [CU-1:0] C_B_U = CU'(Q_B_U);
    localparam logic [CU-1:0] C_R_V = CU'(Q_R_V);
    localparam logic [CU-1:0] C_G_V = CU'(Q_G_V);
    localparam logic [CU-1:0] C_B_V = CU'(Q_B_V);

    logic [PIX_W-1:0]        alpha_reg;
    logic [NSTG-1:0]         vld_reg;
    logic                    adv;

    logic signed [PIX_W-1:0] u_s, v_s;
    logic signed [PW-1:0]    pr_reg, pg_reg, pb_reg;
    logic signed [PW-1:0]    pr_next, pg_next, pb_next;
    logic [PIX_W-1:0]        luma_s1_reg [NPIX];
    logic [PIX_W-1:0]        luma_s1_next [NPIX];
    logic signed [TW-1:0]    tr, tg, tb;
    yfr_delta_t              delta;

    yfr_rgb_t                fade [NPIX];
    logic [PIX_W-1:0]        luma_out [NPIX];

    logic [LW-1:0]           ur_reg, ug_reg, ub_reg, vr_reg, vg_reg, vb_reg;
    logic [LW-1:0]           ur_next, ug_next, ub_next, vr_next, vg_next, vb_next;
    logic signed [SW-1:0]    nu_sum, nv_sum;
    logic signed [NW-1:0]    nu_off, nv_off;
    logic [PIX_W-1:0]        cu_reg, cv_reg, cu_next, cv_next;

    function automatic logic signed [TW-1:0] trunc_p(input logic signed [PW-1:0] x);
        logic fix;
        fix = x[PW-1] && (x[COEF_FRAC_BITS-1:0] != '0);
        return $signed(x[PW-1:COEF_FRAC_BITS]) + $signed({{(TW-1){1'b0}}, fix});
    endfunction

    // Truncate toward zero, then restore the chroma offset
    function automatic logic signed [NW-1:0] chroma_off(input logic signed [SW-1:0] x);
        logic                   fix;
        logic signed [NW-2:0]   t;
        fix = x[SW-1] && (x[COEF_FRAC_BITS-1:0] != '0);
        t   = $signed(x[SW-1:COEF_FRAC_BITS]) + $signed({{(NW-2){1'b0}}, fix});
        return NW'(t) + NW'(CHROMA_OFFSET);
    endfunction

    function automatic logic [PIX_W-1:0] clip_c(input logic signed [NW-1:0] s);
        logic [PIX_W-1:0] res;
        if (s[NW-1])
            res = '0;
        else if (s > NW'(PIX_MAX))
            res = PIX_W'(PIX_MAX);
        else
            res = s[PIX_W-1:0];
        return res;
    endfunction

    // Whole pipeline moves unless the output holds an untaken result
    assign adv          = !vld_reg[NSTG-1] || pix_out.ready;
    assign pix_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= PIX_W'(PIX_MAX);
            vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                alpha_reg <= cfg_wdata;
            if (adv)
                vld_reg <= {vld_reg[NSTG-2:0], pix_in.valid};
        end
    end

    // Stage 1: shared chroma products; offset binary to signed by MSB flip
    always_comb
    begin
        u_s = $signed({~pix_in.chroma_u[PIX_W-1], pix_in.chroma_u[PIX_W-2:0]});
        v_s = $signed({~pix_in.chroma_v[PIX_W-1], pix_in.chroma_v[PIX_W-2:0]});
        pr_next = PW'(C_V_R) * PW'(v_s);
        pg_next = PW'(C_U_G) * PW'(u_s) + PW'(C_V_G) * PW'(v_s);
        pb_next = PW'(C_U_B) * PW'(u_s);
        luma_s1_next[0] = pix_in.luma_0;
        luma_s1_next[1] = pix_in.luma_1;
        luma_s1_next[2] = pix_in.luma_2;
        luma_s1_next[3] = pix_in.luma_3;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr_reg      <= pr_next;
            pg_reg      <= pg_next;
            pb_reg      <= pb_next;
            luma_s1_reg <= luma_s1_next;
        end
    end

    always_comb
    begin
        tr = trunc_p(pr_reg);
        tg = trunc_p(pg_reg);
        tb = trunc_p(pb_reg);
        delta.r = DELTA_W'(tr);
        delta.g = DELTA_W'(-tg);
        delta.b = DELTA_W'(tb);
    end

    // Stages 2 to 5 per pixel
    for (genvar k = 0; k < NPIX; k++)
    begin : g_pix
        yfr_pixel #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_pix (
            .clk      (clk),
            .en       (adv),
            .alpha    (alpha_reg),
            .luma     (luma_s1_reg[k]),
            .delta    (delta),
            .fade     (fade[k]),
            .luma_out (luma_out[k])
        );
    end

    // Stage 4: chroma products from the faded top-left pixel
    always_comb
    begin
        ur_next = LW'(C_R_U) * LW'(fade[0].r);
        ug_next = LW'(C_G_U) * LW'(fade[0].g);
        ub_next = LW'(C_B_U) * LW'(fade[0].b);
        vr_next = LW'(C_R_V) * LW'(fade[0].r);
        vg_next = LW'(C_G_V) * LW'(fade[0].g);
        vb_next = LW'(C_B_V) * LW'(fade[0].b);
    end

    // Stage 5: signed sum, truncate, offset and clip
    always_comb
    begin
        nu_sum  = $signed(SW'(ub_reg) - SW'(ur_reg) - SW'(ug_reg));
        nv_sum  = $signed(SW'(vr_reg) - SW'(vg_reg) - SW'(vb_reg));
        nu_off  = chroma_off(nu_sum);
        nv_off  = chroma_off(nv_sum);
        cu_next = clip_c(nu_off);
        cv_next = clip_c(nv_off);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ur_reg <= ur_next;
            ug_reg <= ug_next;
            ub_reg <= ub_next;
            vr_reg <= vr_next;
            vg_reg <= vg_next;
            vb_reg <= vb_next;
            cu_reg <= cu_next;
            cv_reg <= cv_next;
        end
    end

    assign pix_out.valid        = vld_reg[NSTG-1];
    assign pix_out.out_luma_0   = luma_out[0];
    assign pix_out.out_luma_1   = luma_out[1];
    assign pix_out.out_luma_2   = luma_out[2];
    assign pix_out.out_luma_3   = luma_out[3];
    assign pix_out.out_chroma_u = cu_reg;
    assign pix_out.out_chroma_v = cv_reg;

    // An accepted request reaches the output once the pipeline advances through every later stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_in.valid && pix_in.ready) ##1 adv ##1 adv ##1 adv ##1 adv
        |=> pix_out.valid)
        else $error("accepted block did not reach the output");

    // Hold all stage valid bits while the pipeline is halted
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("stage valid bits moved during a halt");

    // A new result only arrives from a filled fourth stage
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && !$past(pix_out.valid) |-> $past(vld_reg[NSTG-2]))
        else $error("result appeared without a preceding stage");

endmodule
